[sv/popc_pkg.sv]
// shared types and constants for the periodic overlap placement check
package popc_pkg;

  localparam int DEFAULT_MAX_PARTICLES = 256;
  localparam int CoordW = 24;
  localparam int FracW  = 16;
  localparam int RadW   = 16;
  localparam int SlotW  = 8;
  localparam int CfgIdxW = 2;

  localparam logic [CoordW-1:0] RST_LENGTH   = 24'd1280;
  localparam logic [CoordW-1:0] RST_Z_OFFSET = 24'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LENGTH_X = 2'd0,
    REG_LENGTH_Y = 2'd1,
    REG_LENGTH_Z = 2'd2,
    REG_Z_OFFSET = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    RES_ACCEPT = 2'd0,
    RES_REJECT = 2'd1,
    RES_FULL   = 2'd2,
    RES_CLEAR  = 2'd3
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_POS_Z,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  mul_en;
    axis_t mul_axis;
    logic  scan_init;
    logic  issue;
    logic  flush;
    logic  write;
    logic  clear;
    logic  emit;
    res_t  res;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic scan_done;
  } dp_status_t;

endpackage

[sv/periodic_overlap_placement_check_core.sv]
// top level of the periodic overlap placement check
// A place item scales its position one axis at a time on one shared multiplier, then
// reads the particle table memory one entry per cycle into a five-stage minimum-image
// distance pipeline. A rejection on any entry ends the scan early. A full table is
// answered without a scan and a clear item empties the table. busy is high while an
// item is in work. out_valid marks each result for one cycle and must be taken then.
// Configuration writes are always ready.
module periodic_overlap_placement_check_core
  import popc_pkg::*;
#(
  parameter int MAX_PARTICLES = DEFAULT_MAX_PARTICLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [FracW-1:0]   in_frac_x,
  input  logic [FracW-1:0]   in_frac_y,
  input  logic [FracW-1:0]   in_frac_z,
  input  logic [RadW-1:0]    in_radius,
  output logic               out_valid,
  output logic               out_accepted,
  output logic               out_table_full,
  output logic [SlotW-1:0]   out_slot_index,
  output logic [CoordW-1:0]  out_pos_x,
  output logic [CoordW-1:0]  out_pos_y,
  output logic [CoordW-1:0]  out_pos_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CoordW-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       ctrl_busy;

  assign cfg_ready = 1'b1;
  assign busy = ctrl_busy;

  popc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (ctrl_busy)
  );

  popc_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_frac_x      (in_frac_x),
    .in_frac_y      (in_frac_y),
    .in_frac_z      (in_frac_z),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .out_table_full (out_table_full),
    .out_slot_index (out_slot_index),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z)
  );

endmodule

[sv/popc_ctrl.sv]
// controller state machine sequencing position forming and the table scan
module popc_ctrl
  import popc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_operation,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mul_axis = AXIS_X;
    cmd.res = RES_ACCEPT;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = in_operation ? ST_CLEAR : ST_MUL_X;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        cmd.emit = 1'b1;
        cmd.res = RES_CLEAR;
        state_nxt = ST_IDLE;
      end
      ST_MUL_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_axis = AXIS_X;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_en = 1'b1;
        cmd.mul_axis = AXIS_Y;
        state_nxt = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd.mul_en = 1'b1;
        cmd.mul_axis = AXIS_Z;
        state_nxt = ST_POS_Z;
      end
      ST_POS_Z: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.full) begin
          cmd.emit = 1'b1;
          cmd.res = RES_FULL;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.hit) begin
          cmd.flush = 1'b1;
          cmd.emit = 1'b1;
          cmd.res = RES_REJECT;
          state_nxt = ST_IDLE;
        end else if (status.scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        cmd.emit = 1'b1;
        cmd.res = RES_ACCEPT;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[sv/popc_dp.sv]
// datapath: config registers, position multiplier, particle table and check pipeline
module popc_dp
  import popc_pkg::*;
#(
  parameter int MAX_PARTICLES = DEFAULT_MAX_PARTICLES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CoordW-1:0]   cfg_data,
  input  logic [FracW-1:0]    in_frac_x,
  input  logic [FracW-1:0]    in_frac_y,
  input  logic [FracW-1:0]    in_frac_z,
  input  logic [RadW-1:0]     in_radius,
  output logic                out_valid,
  output logic                out_accepted,
  output logic                out_table_full,
  output logic [SlotW-1:0]    out_slot_index,
  output logic [CoordW-1:0]   out_pos_x,
  output logic [CoordW-1:0]   out_pos_y,
  output logic [CoordW-1:0]   out_pos_z
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int WordW = 3 * CoordW + RadW;
  localparam int ProdW = FracW + CoordW;
  localparam int SqW = 2 * CoordW;
  localparam int D2W = SqW + 2;
  localparam int RsW = RadW + 1;
  localparam int Rs2W = 2 * RsW;
  localparam int Rs9W = Rs2W + 4;
  localparam int CmpW = D2W + 2;

  // configuration
  logic [CoordW-1:0] len_r [3];
  logic [CoordW-1:0] z_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0] <= RST_LENGTH;
      len_r[1] <= RST_LENGTH;
      len_r[2] <= RST_LENGTH;
      z_off_r <= RST_Z_OFFSET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LENGTH_X: len_r[0] <= cfg_data;
        REG_LENGTH_Y: len_r[1] <= cfg_data;
        REG_LENGTH_Z: len_r[2] <= cfg_data;
        REG_Z_OFFSET: z_off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic [FracW-1:0] frac_r [3];
  logic [RadW-1:0]  rad_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frac_r[0] <= in_frac_x;
      frac_r[1] <= in_frac_y;
      frac_r[2] <= in_frac_z;
      rad_r <= in_radius;
    end
  end

  // position forming, one axis per cycle
  logic [FracW-1:0]  mul_frac;
  logic [CoordW-1:0] mul_len;
  logic [ProdW-1:0]  prod_r;
  axis_t             prod_axis_r;
  logic              prod_vld_r;
  logic [CoordW-1:0] pos_r [3];
  logic [CoordW-1:0] scaled;
  logic [CoordW:0]   z_sum;

  always_comb begin
    unique case (cmd.mul_axis)
      AXIS_X: begin
        mul_frac = frac_r[0];
        mul_len = len_r[0];
      end
      AXIS_Y: begin
        mul_frac = frac_r[1];
        mul_len = len_r[1];
      end
      AXIS_Z: begin
        mul_frac = frac_r[2];
        mul_len = len_r[2];
      end
      default: begin
        mul_frac = '0;
        mul_len = '0;
      end
    endcase
  end

  assign scaled = prod_r[ProdW-1:FracW];
  assign z_sum = {1'b0, scaled} + {1'b0, z_off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= ProdW'(mul_frac) * ProdW'(mul_len);
      prod_axis_r <= cmd.mul_axis;
    end
    if (prod_vld_r) begin
      unique case (prod_axis_r)
        AXIS_X: pos_r[0] <= scaled;
        AXIS_Y: pos_r[1] <= scaled;
        AXIS_Z: pos_r[2] <= z_sum[CoordW] ? {CoordW{1'b1}} : z_sum[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // particle table
  logic [WordW-1:0] mem [MAX_PARTICLES];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    rd_idx_r;
  logic [WordW-1:0] rd_q_r;
  logic             do_issue;

  assign do_issue = cmd.issue && (rd_idx_r != count_r);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[count_r[AW-1:0]] <= {pos_r[0], pos_r[1], pos_r[2], rad_r};
    end
    if (do_issue) begin
      rd_q_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.write) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_init) begin
        rd_idx_r <= '0;
      end else if (do_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // check pipeline
  logic [4:0]        vld_r;
  logic [CoordW-1:0] sep_r [3];
  logic [RsW-1:0]    rsum_r;
  logic [SqW-1:0]    sq_r [3];
  logic [Rs2W-1:0]   rs2_r;
  logic [D2W-1:0]    d2_r;
  logic [Rs9W-1:0]   rs9_r;
  logic              hit_r;
  logic [CoordW-1:0] st_pos [3];
  logic [RadW-1:0]   st_rad;
  logic [CoordW-1:0] sep [3];

  assign st_pos[0] = rd_q_r[WordW-1 -: CoordW];
  assign st_pos[1] = rd_q_r[WordW-CoordW-1 -: CoordW];
  assign st_pos[2] = rd_q_r[RadW+CoordW-1 -: CoordW];
  assign st_rad = rd_q_r[RadW-1:0];

  always_comb begin
    logic [CoordW-1:0] d;
    for (int a = 0; a < 3; a++) begin
      d = (pos_r[a] >= st_pos[a]) ? pos_r[a] - st_pos[a] : st_pos[a] - pos_r[a];
      if ({d, 1'b0} <= {1'b0, len_r[a]}) begin
        sep[a] = d;
      end else if (len_r[a] >= d) begin
        sep[a] = len_r[a] - d;
      end else begin
        sep[a] = d - len_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.flush || cmd.scan_init) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], do_issue};
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sep_r[a] <= sep[a];
      sq_r[a] <= SqW'(sep_r[a]) * SqW'(sep_r[a]);
    end
    rsum_r <= {1'b0, rad_r} + {1'b0, st_rad};
    rs2_r <= Rs2W'(rsum_r) * Rs2W'(rsum_r);
    d2_r <= D2W'(sq_r[0]) + D2W'(sq_r[1]) + D2W'(sq_r[2]);
    rs9_r <= {1'b0, rs2_r, 3'b000} + Rs9W'(rs2_r);
    hit_r <= {d2_r, 2'b00} < CmpW'(rs9_r);
  end

  assign status.full = (count_r >= CW'(MAX_PARTICLES));
  assign status.hit = vld_r[4] && hit_r;
  assign status.scan_done = (rd_idx_r == count_r) && (vld_r == '0);

  // result register
  logic              out_valid_r;
  logic              accepted_r;
  logic              table_full_r;
  logic [SlotW-1:0]  slot_r;
  logic [CoordW-1:0] opos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      accepted_r <= (cmd.res == RES_ACCEPT);
      table_full_r <= (cmd.res == RES_FULL);
      slot_r <= (cmd.res == RES_ACCEPT) ? SlotW'(count_r) : '0;
      for (int a = 0; a < 3; a++) begin
        opos_r[a] <= (cmd.res == RES_CLEAR) ? '0 : pos_r[a];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_accepted = accepted_r;
  assign out_table_full = table_full_r;
  assign out_slot_index = slot_r;
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_PARTICLES))
    else $error("particle count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !status.full)
    else $error("table write while full");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("count did not advance after store");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(accepted_r && table_full_r))
    else $error("result both accepted and full");

endmodule

[sim/popc_result_checker.sv]
// watches the placement check channels, predicts each result and compares it
module popc_result_checker
  import popc_pkg::*;
#(
  parameter int MAX_PARTICLES = DEFAULT_MAX_PARTICLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_operation,
  input  logic [FracW-1:0]   in_frac_x,
  input  logic [FracW-1:0]   in_frac_y,
  input  logic [FracW-1:0]   in_frac_z,
  input  logic [RadW-1:0]    in_radius,
  input  logic               out_valid,
  input  logic               out_accepted,
  input  logic               out_table_full,
  input  logic [SlotW-1:0]   out_slot_index,
  input  logic [CoordW-1:0]  out_pos_x,
  input  logic [CoordW-1:0]  out_pos_y,
  input  logic [CoordW-1:0]  out_pos_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CoordW-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic              accepted;
    logic              table_full;
    logic [SlotW-1:0]  slot_index;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
  } placement_t;

  placement_t expected_results[$];

  logic [CoordW-1:0] box_x, box_y, box_z, z_shift;
  logic [CoordW-1:0] tab_x[MAX_PARTICLES];
  logic [CoordW-1:0] tab_y[MAX_PARTICLES];
  logic [CoordW-1:0] tab_z[MAX_PARTICLES];
  logic [RadW-1:0]   tab_r[MAX_PARTICLES];
  int                n_stored;

  function automatic logic [CoordW-1:0] scale(logic [FracW-1:0] f, logic [CoordW-1:0] len);
    longint unsigned prod;
    prod = longint'(f) * longint'(len);
    return prod[FracW +: CoordW];
  endfunction

  function automatic longint unsigned wrap_sq(logic [CoordW-1:0] a, logic [CoordW-1:0] b,
                                              logic [CoordW-1:0] len);
    longint d, s;
    d = (a >= b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
    s = (2 * d <= longint'(len)) ? d : longint'(len) - d;
    return longint'(s * s);
  endfunction

  function automatic placement_t predict_placement(logic op, logic [FracW-1:0] fx,
                                                   logic [FracW-1:0] fy, logic [FracW-1:0] fz,
                                                   logic [RadW-1:0] rad);
    placement_t p;
    longint unsigned zsum, d2, rs;
    logic hit;
    p = '{default: '0};
    hit = 1'b0;
    if (op) begin
      n_stored = 0;
      return p;
    end
    p.pos_x = scale(fx, box_x);
    p.pos_y = scale(fy, box_y);
    zsum = longint'(scale(fz, box_z)) + longint'(z_shift);
    p.pos_z = (zsum > 64'hFFFFFF) ? 24'hFFFFFF : zsum[CoordW-1:0];
    if (n_stored >= MAX_PARTICLES) begin
      p.table_full = 1'b1;
      return p;
    end
    for (int k = 0; k < n_stored && !hit; k++) begin
      d2 = wrap_sq(p.pos_x, tab_x[k], box_x) + wrap_sq(p.pos_y, tab_y[k], box_y)
         + wrap_sq(p.pos_z, tab_z[k], box_z);
      rs = longint'(rad) + longint'(tab_r[k]);
      if (4 * d2 < 9 * rs * rs) hit = 1'b1;
    end
    if (!hit) begin
      tab_x[n_stored] = p.pos_x;
      tab_y[n_stored] = p.pos_y;
      tab_z[n_stored] = p.pos_z;
      tab_r[n_stored] = rad;
      p.accepted = 1'b1;
      p.slot_index = n_stored[SlotW-1:0];
      n_stored++;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    placement_t e;
    if (!rst_n) begin
      box_x <= RST_LENGTH;
      box_y <= RST_LENGTH;
      box_z <= RST_LENGTH;
      z_shift <= RST_Z_OFFSET;
      n_stored = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_accepted !== e.accepted ||
              out_table_full !== e.table_full ||
              out_slot_index !== e.slot_index ||
              out_pos_x !== e.pos_x || out_pos_y !== e.pos_y || out_pos_z !== e.pos_z)
            fail_count <= fail_count + 1;
          if (out_accepted !== e.accepted)
            $error("accepted: expected %0d, got %0d", e.accepted, out_accepted);
          if (out_table_full !== e.table_full)
            $error("table_full: expected %0d, got %0d", e.table_full, out_table_full);
          if (out_slot_index !== e.slot_index)
            $error("slot_index: expected %0d, got %0d", e.slot_index, out_slot_index);
          if (out_pos_x !== e.pos_x)
            $error("pos_x: expected %0h, got %0h", e.pos_x, out_pos_x);
          if (out_pos_y !== e.pos_y)
            $error("pos_y: expected %0h, got %0h", e.pos_y, out_pos_y);
          if (out_pos_z !== e.pos_z)
            $error("pos_z: expected %0h, got %0h", e.pos_z, out_pos_z);
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_placement(in_operation, in_frac_x, in_frac_y,
                                                     in_frac_z, in_radius));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_LENGTH_X: box_x <= cfg_data;
          REG_LENGTH_Y: box_y <= cfg_data;
          REG_LENGTH_Z: box_z <= cfg_data;
          REG_Z_OFFSET: z_shift <= cfg_data;
          default: ;
        endcase
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

[sim/tb_periodic_overlap_placement_check_core.sv]
// testbench top: stimulus, configuration phases and verdict for the placement check
module tb_periodic_overlap_placement_check_core;
  import popc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 350;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = 1'b0;
  logic [FracW-1:0]   in_frac_x = '0;
  logic [FracW-1:0]   in_frac_y = '0;
  logic [FracW-1:0]   in_frac_z = '0;
  logic [RadW-1:0]    in_radius = '0;
  logic               out_valid;
  logic               out_accepted;
  logic               out_table_full;
  logic [SlotW-1:0]   out_slot_index;
  logic [CoordW-1:0]  out_pos_x, out_pos_y, out_pos_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoordW-1:0]  cfg_data = '0;
  int                 fail_count;
  int                 pending_count;
  int                 idle_pct;
  int                 clear_odds;
  longint             cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  periodic_overlap_placement_check_core DUT (.*);

  popc_result_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_periodic_overlap_placement_check_core NOT OK");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send(logic op, logic [FracW-1:0] fx, logic [FracW-1:0] fy,
                      logic [FracW-1:0] fz, logic [RadW-1:0] rad);
    while ($urandom_range(99) < idle_pct || busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_operation = op;
    in_frac_x = fx;
    in_frac_y = fy;
    in_frac_z = fz;
    in_radius = rad;
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    @(negedge clk);
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CoordW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_box(logic [CoordW-1:0] lx, logic [CoordW-1:0] ly,
                         logic [CoordW-1:0] lz, logic [CoordW-1:0] zo);
    drain();
    write_reg(REG_LENGTH_X, lx);
    write_reg(REG_LENGTH_Y, ly);
    write_reg(REG_LENGTH_Z, lz);
    write_reg(REG_Z_OFFSET, zo);
  endtask

  task automatic random_places(int n);
    int sel;
    logic [RadW-1:0] r;
    repeat (n) begin
      sel = $urandom_range(99);
      r = (sel < 70) ? RadW'($urandom_range(48)) :
          (sel < 90) ? RadW'($urandom) : RadW'($urandom_range(65535, 40000));
      if ($urandom_range(clear_odds - 1) == 0)
        send(1'b1, FracW'($urandom), FracW'($urandom), FracW'($urandom), RadW'($urandom));
      else
        send(1'b0, FracW'($urandom), FracW'($urandom), FracW'($urandom), r);
    end
  endtask

  initial begin
    idle_pct = 0;
    clear_odds = 30;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    set_box(RST_LENGTH, RST_LENGTH, RST_LENGTH, RST_Z_OFFSET);

    // directed: corners, wrap across the box edge, overlap and clear
    send(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0010);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send(1'b0, 16'h4000, 16'hC000, 16'h2000, 16'h0040);
    send(1'b0, 16'h4100, 16'hC000, 16'h2000, 16'h0040);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h00FF);
    send(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    set_box(24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send(1'b0, 16'h0000, 16'h7FFF, 16'h0000, 16'h0001);
    send(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    random_places(PHASE_ITEMS);

    // box huge in x and y, flat in z, with rare clears so the table fills up
    idle_pct = 46;
    clear_odds = 400;
    set_box(24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'hFFFFFF);
    random_places(PHASE_ITEMS);

    idle_pct = 29;
    clear_odds = 30;
    set_box(24'd1, 24'd4096, 24'd300000, 24'd12345);
    random_places(PHASE_ITEMS);

    idle_pct = 0;
    clear_odds = 60;
    set_box(CoordW'($urandom_range(24'hFFFFFF, 1)), CoordW'($urandom_range(5000, 1)),
            CoordW'($urandom_range(24'hFFFFFF, 1)), CoordW'($urandom));
    random_places(PHASE_ITEMS);

    drain();
    if (fail_count == 0)
      $display("tb_periodic_overlap_placement_check_core OK");
    else
      $display("tb_periodic_overlap_placement_check_core NOT OK");
    $finish;
  end

endmodule
